/* design/srt_pkg.sv */
// Shared types and constants for the server registry table.
// Depends on nothing; srt_core and server_registry_table refer to it by scoped name.
`default_nettype none

package srt_pkg;

    localparam int MAX_SERVERS = 64;
    localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

    localparam logic [7:0] OP_HEARTBEAT = 8'h61;
    localparam logic [7:0] OP_LIST      = 8'h63;
    localparam logic [7:0] OP_PING      = 8'h6b;
    localparam logic [7:0] OP_SHUTDOWN  = 8'h43;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_REFRESHED = 3'd1;
    localparam logic [2:0] ST_ENTRY     = 3'd2;
    localparam logic [2:0] ST_ACK       = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_INVALID   = 3'd5;

    typedef struct packed {
        logic [7:0]  op;
        logic [31:0] client_ip;
        logic [15:0] client_port;
        logic [31:0] now_time;
    } srt_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        table_full;
        logic        entry_valid;
        logic [31:0] entry_ip;
        logic [15:0] entry_port;
        logic [31:0] age;
        logic        last;
    } srt_out_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] heard;
    } srt_entry_t;

    localparam int ENTRY_W = $bits(srt_entry_t);

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        srt_entry_t       wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } srt_ram_req_t;

endpackage

`default_nettype wire

/* design/srt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module srt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/srt_core.sv */
// Sequencer for the server registry: scan, update, compaction and listing.
// Depends on srt_pkg; drives the entry RAM through an srt_ram_req_t bundle.
`default_nettype none

module srt_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire srt_pkg::srt_in_t     s_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output srt_pkg::srt_out_t         res,
    output srt_pkg::srt_ram_req_t     ram_req,
    input  wire srt_pkg::srt_entry_t  ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_MRD,
        S_MWR,
        S_EMIT,
        S_LRD,
        S_LDATA
    } state_t;

    state_t                        state_reg, state_next;
    logic [srt_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic [srt_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [srt_pkg::CNT_W-1:0]     idx_plus;
    srt_pkg::srt_in_t              in_reg, in_next;
    srt_pkg::srt_out_t             res_reg, res_next;
    srt_pkg::srt_out_t             list_res;
    logic                          match;
    logic [31:0]                   age_diff;

    localparam logic [srt_pkg::CNT_W-1:0] COUNT_MAX = srt_pkg::CNT_W'(srt_pkg::MAX_SERVERS);

    assign idx_plus = idx_reg + srt_pkg::CNT_W'(1);
    assign match    = (ram_rdata.ip == in_reg.client_ip) &&
                      (ram_rdata.port == in_reg.client_port);
    assign age_diff = in_reg.now_time - ram_rdata.heard;

    always_comb begin
        list_res             = '0;
        list_res.status      = srt_pkg::ST_ENTRY;
        list_res.entry_valid = 1'b1;
        list_res.entry_ip    = ram_rdata.ip;
        list_res.entry_port  = ram_rdata.port;
        list_res.last        = (idx_plus == count_reg);
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        in_next    = in_reg;
        res_next   = res_reg;

        ram_req.wr_en         = 1'b0;
        ram_req.wr_addr       = idx_reg[srt_pkg::IDX_W-1:0];
        ram_req.wr_data.ip    = in_reg.client_ip;
        ram_req.wr_data.port  = in_reg.client_port;
        ram_req.wr_data.heard = in_reg.now_time;
        ram_req.rd_en         = 1'b0;
        ram_req.rd_addr       = idx_reg[srt_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next         = s_data;
                    idx_next        = '0;
                    res_next        = '0;
                    res_next.status = srt_pkg::ST_INVALID;
                    res_next.last   = 1'b1;
                    case (s_data.op)
                        srt_pkg::OP_HEARTBEAT, srt_pkg::OP_SHUTDOWN: begin
                            state_next = S_SRD;
                        end
                        srt_pkg::OP_LIST: begin
                            if (count_reg == '0) begin
                                res_next.status = srt_pkg::ST_ENTRY;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_LRD;
                            end
                        end
                        srt_pkg::OP_PING: begin
                            res_next.status = srt_pkg::ST_ACK;
                            state_next      = S_EMIT;
                        end
                        default: begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_SRD: begin
                if (idx_reg == count_reg) begin
                    if (in_reg.op == srt_pkg::OP_HEARTBEAT) begin
                        if (count_reg == COUNT_MAX) begin
                            res_next.table_full = 1'b1;
                        end else begin
                            ram_req.wr_en   = 1'b1;
                            count_next      = idx_plus;
                            res_next.status = srt_pkg::ST_ADDED;
                        end
                    end
                    state_next = S_EMIT;
                end else begin
                    ram_req.rd_en = 1'b1;
                    state_next    = S_SCMP;
                end
            end
            S_SCMP: begin
                if (match) begin
                    res_next.age = age_diff;
                    if (in_reg.op == srt_pkg::OP_HEARTBEAT) begin
                        ram_req.wr_en   = 1'b1;
                        res_next.status = srt_pkg::ST_REFRESHED;
                        state_next      = S_EMIT;
                    end else begin
                        res_next.status = srt_pkg::ST_REMOVED;
                        state_next      = S_MRD;
                    end
                end else begin
                    idx_next   = idx_plus;
                    state_next = S_SRD;
                end
            end
            S_MRD: begin
                if (idx_plus >= count_reg) begin
                    count_next = count_reg - srt_pkg::CNT_W'(1);
                    state_next = S_EMIT;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_plus[srt_pkg::IDX_W-1:0];
                    state_next      = S_MWR;
                end
            end
            S_MWR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_data = ram_rdata;
                idx_next        = idx_plus;
                state_next      = S_MRD;
            end
            S_EMIT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_LRD: begin
                ram_req.rd_en = 1'b1;
                state_next    = S_LDATA;
            end
            S_LDATA: begin
                if (res_ready) begin
                    if (idx_plus == count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_plus;
                        state_next = S_LRD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
        in_reg  <= in_next;
        res_reg <= res_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT) || (state_reg == S_LDATA);
    assign res       = (state_reg == S_LDATA) ? list_res : res_reg;

    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_valid)
        else $error("result offered while taking a new transfer");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready again directly after a transfer");

    a_list_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LDATA) |-> (idx_reg < count_reg))
        else $error("listing beyond the live entries");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.wr_en |-> ((idx_reg < count_reg) ||
                           ((idx_reg == count_reg) && (count_reg < COUNT_MAX))))
        else $error("entry write outside the live table");

endmodule

`default_nettype wire

/* design/server_registry_table.sv */
// Server registry table: one input transfer per packet, results through an output register.
// A heartbeat or shutdown scans the table one entry at a time, a read and then a compare,
// up to the match (or the whole table when the sender is unknown), because the single read
// port of the entry RAM delivers one registered entry per lookup; a shutdown then moves
// each later entry down one place with a read and a write. A list request reads and offers
// one entry at a time and waits on any output stall; a ping or unknown command goes straight
// to its result. The input is not ready while an item is in progress. No clearing pass is
// needed after reset: only the sequencer state, index and entry count are cleared.
// Depends on srt_pkg, srt_core and srt_ram.
`default_nettype none

module server_registry_table (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire srt_pkg::srt_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output srt_pkg::srt_out_t      m_data
);

    logic                   res_valid;
    logic                   res_ready;
    srt_pkg::srt_out_t      res;
    srt_pkg::srt_ram_req_t  ram_req;
    srt_pkg::srt_entry_t    ram_rdata;
    logic                   m_valid_reg;
    srt_pkg::srt_out_t      m_data_reg;

    srt_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    srt_ram #(
        .WIDTH (srt_pkg::ENTRY_W),
        .DEPTH (srt_pkg::MAX_SERVERS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench for server_registry_table: a scoreboard class keeps its own registry and predicts
// every result of each accepted packet; plain tasks drive directed and random packets.
// Depends on srt_pkg and the server_registry_table RTL.

module tb;

    localparam logic [7:0] OP_BAD_ZERO  = 8'h00;
    localparam logic [7:0] OP_BAD_ONES  = 8'hFF;
    localparam logic [7:0] OP_BAD_UPPER = 8'h41;
    localparam logic [7:0] OP_BAD_NEAR  = 8'h62;
    localparam int         POOL         = 96;
    localparam int         HOLD_CYCLES  = 400;

    class registry_scoreboard;
        logic [31:0]       reg_ip[srt_pkg::MAX_SERVERS];
        logic [15:0]       reg_port[srt_pkg::MAX_SERVERS];
        logic [31:0]       reg_heard[srt_pkg::MAX_SERVERS];
        int                reg_count;
        srt_pkg::srt_out_t pending_q[$];
        int                mismatches;
        int                checked;
        int                full_hits;
        int                peak;
        int                lists;

        function new();
            reg_count  = 0;
            mismatches = 0;
            checked    = 0;
            full_hits  = 0;
            peak       = 0;
            lists      = 0;
        endfunction

        function int lookup(logic [31:0] ip, logic [15:0] port);
            for (int i = 0; i < reg_count; i++)
                if (reg_ip[i] == ip && reg_port[i] == port) return i;
            return reg_count;
        endfunction

        function void note_packet(srt_pkg::srt_in_t p);
            srt_pkg::srt_out_t r;
            int                idx;
            r      = '0;
            r.last = 1'b1;
            case (p.op)
                srt_pkg::OP_HEARTBEAT: begin
                    idx = lookup(p.client_ip, p.client_port);
                    if (idx < reg_count) begin
                        r.status       = srt_pkg::ST_REFRESHED;
                        r.age          = p.now_time - reg_heard[idx];
                        reg_heard[idx] = p.now_time;
                    end else if (reg_count >= srt_pkg::MAX_SERVERS) begin
                        r.status     = srt_pkg::ST_INVALID;
                        r.table_full = 1'b1;
                        full_hits++;
                    end else begin
                        reg_ip[reg_count]    = p.client_ip;
                        reg_port[reg_count]  = p.client_port;
                        reg_heard[reg_count] = p.now_time;
                        reg_count++;
                        if (reg_count > peak) peak = reg_count;
                        r.status = srt_pkg::ST_ADDED;
                    end
                end
                srt_pkg::OP_LIST: begin
                    lists++;
                    r.status = srt_pkg::ST_ENTRY;
                    if (reg_count == 0) pending_q.push_back(r);
                    for (int i = 0; i < reg_count; i++) begin
                        r.entry_valid = 1'b1;
                        r.entry_ip    = reg_ip[i];
                        r.entry_port  = reg_port[i];
                        r.last        = (i == reg_count - 1);
                        pending_q.push_back(r);
                    end
                    return;
                end
                srt_pkg::OP_PING: begin
                    r.status = srt_pkg::ST_ACK;
                end
                srt_pkg::OP_SHUTDOWN: begin
                    idx = lookup(p.client_ip, p.client_port);
                    if (idx < reg_count) begin
                        r.status = srt_pkg::ST_REMOVED;
                        r.age    = p.now_time - reg_heard[idx];
                        // close the gap, keeping table order
                        for (int j = idx; j + 1 < reg_count; j++) begin
                            reg_ip[j]    = reg_ip[j + 1];
                            reg_port[j]  = reg_port[j + 1];
                            reg_heard[j] = reg_heard[j + 1];
                        end
                        reg_count--;
                    end else begin
                        r.status = srt_pkg::ST_INVALID;
                    end
                end
                default: begin
                    r.status = srt_pkg::ST_INVALID;
                end
            endcase
            pending_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                mismatches++;
                $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
            end
        endfunction

        function void check_result(srt_pkg::srt_out_t got);
            srt_pkg::srt_out_t want;
            if (pending_q.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with nothing expected, expected none, got %h",
                         $time, got);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("table_full", 32'(want.table_full), 32'(got.table_full));
            compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
            compare_field("entry_ip", want.entry_ip, got.entry_ip);
            compare_field("entry_port", 32'(want.entry_port), 32'(got.entry_port));
            compare_field("age", want.age, got.age);
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    srt_pkg::srt_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    srt_pkg::srt_out_t m_data;

    registry_scoreboard sb;
    int          tx_idle_pct = 34;
    int          rx_idle_pct = 48;
    bit          hold_request = 1'b0;
    int          sent = 0;
    logic [31:0] now_s = '0;
    logic [31:0] pool_ip[POOL];
    logic [15:0] pool_port[POOL];

    server_registry_table DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic srt_pkg::srt_in_t make_packet(logic [7:0] op, logic [31:0] ip,
                                                     logic [15:0] port, logic [31:0] t);
        srt_pkg::srt_in_t p;
        p.op          = op;
        p.client_ip   = ip;
        p.client_port = port;
        p.now_time    = t;
        return p;
    endfunction

    function automatic logic [31:0] next_time();
        if ($urandom_range(99) < 8) now_s = $urandom;
        else now_s = now_s + $urandom_range(0, 40);
        return now_s;
    endfunction

    task automatic send_packet(input srt_pkg::srt_in_t p);
        int gap;
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_packet(p);
        sent++;
    endtask

    task automatic send_random_packet();
        int          pick;
        int          idx;
        logic [7:0]  op;
        logic [31:0] ip;
        logic [15:0] port;
        pick = $urandom_range(99);
        if (sb.reg_count > 0 && $urandom_range(1) == 1) begin
            idx  = $urandom_range(sb.reg_count - 1);
            ip   = sb.reg_ip[idx];
            port = sb.reg_port[idx];
        end else begin
            idx  = $urandom_range(POOL - 1);
            ip   = pool_ip[idx];
            port = pool_port[idx];
        end
        if (pick < 45) op = srt_pkg::OP_HEARTBEAT;
        else if (pick < 60) op = srt_pkg::OP_SHUTDOWN;
        else if (pick < 70) op = srt_pkg::OP_LIST;
        else if (pick < 78) op = srt_pkg::OP_PING;
        else if (pick < 88) op = 8'($urandom_range(255));
        else begin
            op   = pick[0] ? srt_pkg::OP_HEARTBEAT : srt_pkg::OP_SHUTDOWN;
            ip   = $urandom;
            port = 16'($urandom_range(65535));
        end
        send_packet(make_packet(op, ip, port, next_time()));
    endtask

    task automatic fill_table();
        int k;
        k = 0;
        while (sb.reg_count < srt_pkg::MAX_SERVERS) begin
            send_packet(make_packet(srt_pkg::OP_HEARTBEAT, 32'(32'h0A00_0000 + k), 16'(k),
                                    next_time()));
            k++;
        end
        repeat (3) send_packet(make_packet(srt_pkg::OP_HEARTBEAT, $urandom,
                                           16'($urandom_range(65535)), next_time()));
        send_packet(make_packet(srt_pkg::OP_HEARTBEAT, sb.reg_ip[5], sb.reg_port[5],
                                next_time()));
        send_packet(make_packet(srt_pkg::OP_LIST, '0, '0, next_time()));
        send_packet(make_packet(srt_pkg::OP_SHUTDOWN, sb.reg_ip[0], sb.reg_port[0],
                                next_time()));
        send_packet(make_packet(srt_pkg::OP_SHUTDOWN, sb.reg_ip[srt_pkg::MAX_SERVERS - 2],
                                sb.reg_port[srt_pkg::MAX_SERVERS - 2], next_time()));
        send_packet(make_packet(srt_pkg::OP_LIST, '0, '0, next_time()));
    endtask

    // receiver: check each result transfer, then choose ready for the next cycle
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #(64'd16_000_000);
        $display("Timeout with %0d results outstanding", sb.pending_q.size());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        sb = new();
        for (int i = 0; i < POOL; i++) begin
            pool_ip[i]   = (i > 0 && $urandom_range(3) == 0) ? pool_ip[i - 1] : $urandom;
            pool_port[i] = 16'($urandom_range(65535));
        end
        pool_ip[0]   = '0;
        pool_port[0] = '0;
        pool_ip[1]   = '1;
        pool_port[1] = '1;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_packet(make_packet(srt_pkg::OP_LIST, '0, '0, '0));
        send_packet(make_packet(srt_pkg::OP_PING, 32'h0102_0304, 16'd80, 32'd1));
        send_packet(make_packet(srt_pkg::OP_SHUTDOWN, 32'h0102_0304, 16'd80, 32'd2));
        send_packet(make_packet(OP_BAD_ZERO, '0, '0, '0));
        send_packet(make_packet(OP_BAD_ONES, '1, '1, '1));
        send_packet(make_packet(srt_pkg::OP_HEARTBEAT, '0, '0, '0));
        send_packet(make_packet(srt_pkg::OP_HEARTBEAT, '1, '1, '1));
        send_packet(make_packet(srt_pkg::OP_HEARTBEAT, '0, '0, 32'd5));
        send_packet(make_packet(srt_pkg::OP_HEARTBEAT, '1, '1, 32'd3));
        send_packet(make_packet(srt_pkg::OP_HEARTBEAT, '0, '1, 32'd10));
        send_packet(make_packet(srt_pkg::OP_HEARTBEAT, '1, '0, 32'd10));
        send_packet(make_packet(srt_pkg::OP_LIST, '1, '1, 32'd11));
        send_packet(make_packet(srt_pkg::OP_SHUTDOWN, '1, '1, 32'd20));
        send_packet(make_packet(srt_pkg::OP_LIST, '0, '0, 32'd21));
        send_packet(make_packet(srt_pkg::OP_SHUTDOWN, '1, '1, 32'd22));
        send_packet(make_packet(OP_BAD_UPPER, '0, '0, 32'd23));
        send_packet(make_packet(OP_BAD_NEAR, '1, '1, 32'd24));
        send_packet(make_packet(srt_pkg::OP_PING, '1, '1, '1));
        send_packet(make_packet(srt_pkg::OP_SHUTDOWN, '0, '0, 32'd1));
        send_packet(make_packet(srt_pkg::OP_LIST, '0, '0, 32'd30));
        send_packet(make_packet(srt_pkg::OP_SHUTDOWN, '1, '0, 32'd31));
        send_packet(make_packet(srt_pkg::OP_LIST, '0, '0, 32'd32));
        now_s = 32'd100;

        for (int n = 0; n < 290; n++) begin
            if (n == 100) begin
                tx_idle_pct = 48;
                rx_idle_pct = 34;
            end
            if (n == 200) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (n == 40) hold_request = 1'b1;
            if (n == 150) fill_table();
            send_random_packet();
        end
        s_valid <= 1'b0;

        while (sb.pending_q.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("Covered %0d packets, %0d result transfers checked, %0d list requests.",
                 sent, sb.checked, sb.lists);
        $display("Peak occupancy %0d of %0d, %0d heartbeats refused on a full table.",
                 sb.peak, srt_pkg::MAX_SERVERS, sb.full_hits);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
